// ===== src/assert_macros.svh =====
// Assertion macros for the deque block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define DEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_BACK       = 3'd4,
        OP_FRONT      = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One issued item, handed from the pointer logic to the result stage
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic              use_mem;
        logic [DATA_W-1:0] data;
    } deq_issue_t;

endpackage

// ===== src/deq_if.sv =====
interface deq_in_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink   (input valid, input status, input data_out, output ready);
endinterface

// ===== src/deq_ram.sv =====
module deq_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
    input  logic [WIDTH_P-1:0]         wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
    output logic [WIDTH_P-1:0]         rd_data
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/deq_ctrl.sv =====
`include "assert_macros.svh"

module deq_ctrl import deq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    deq_in_if.sink            req,
    input  logic              issue_ok,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output deq_issue_t        issue
);

    localparam logic [CNT_W:0]    DEPTH_S   = (CNT_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              accept;
    opcode_t           op;
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] front_inc;
    logic [ADDR_W-1:0] front_dec;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    last_sum;
    logic [CNT_W:0]    tail_pos;
    logic [CNT_W:0]    last_pos;

    assign req.ready = issue_ok;
    assign accept    = req.valid && issue_ok;
    assign op        = opcode_t'(req.opcode);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_CNT);

    assign front_inc = (front_reg == LAST_ADDR) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_ADDR : front_reg - 1'b1;

    // slot after the back element, and the back element itself
    assign tail_sum = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign last_sum = tail_sum - 1'b1;
    assign tail_pos = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign last_pos = (last_sum >= DEPTH_S) ? last_sum - DEPTH_S : last_sum;

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_pos[ADDR_W-1:0];
        wr_data        = DATA_W'(req.push_value);
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        issue.valid    = accept;
        issue.status   = ST_OK;
        issue.use_mem  = 1'b0;
        issue.data     = '0;

        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    issue.status = ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    count_next = accept ? count_reg + 1'b1 : count_reg;
                    if (op == OP_PUSH_FRONT)
                    begin
                        wr_addr    = front_dec;
                        front_next = accept ? front_dec : front_reg;
                    end
                end
            end
            OP_POP_BACK, OP_BACK:
            begin
                rd_addr = last_pos[ADDR_W-1:0];
                if (empty)
                begin
                    issue.status = ST_EMPTY;
                end
                else
                begin
                    rd_en         = accept;
                    issue.use_mem = 1'b1;
                    if (op == OP_POP_BACK && accept)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_POP_FRONT, OP_FRONT:
            begin
                if (empty)
                begin
                    issue.status = ST_EMPTY;
                end
                else
                begin
                    rd_en         = accept;
                    issue.use_mem = 1'b1;
                    if (op == OP_POP_FRONT && accept)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_SIZE:
            begin
                issue.data = DATA_W'(count_reg);
            end
            OP_CLEAR:
            begin
                if (accept)
                begin
                    front_next = '0;
                    count_next = '0;
                end
            end
            default:
            begin
                issue.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    `DEQ_ASSERT(a_count_range, count_reg <= FULL_CNT, "element count beyond depth")
    `DEQ_ASSERT(a_full_push_holds, accept && full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) |=> $stable(count_reg) && $stable(front_reg), "refused push changed state")
    `DEQ_ASSERT(a_pop_decrements, accept && !empty && (op == OP_POP_BACK || op == OP_POP_FRONT) |=> count_reg + 1'b1 == $past(count_reg), "pop did not drop count by one")

endmodule

// ===== src/deq_result.sv =====
module deq_result import deq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  deq_issue_t        issue,
    input  logic [DATA_W-1:0] rd_data,
    output logic              issue_ok,
    deq_out_if.source         rsp
);

    logic              s1_valid_reg, s1_valid_next;
    status_t           s1_status_reg;
    logic              s1_use_mem_reg;
    logic [DATA_W-1:0] s1_data_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic              move;

    // ring read data lands alongside stage 1; RAM holds it while stage 1 waits
    assign move           = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign issue_ok       = !s1_valid_reg || move;
    assign s1_valid_next  = issue.valid || (s1_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_status_reg  <= issue.status;
            s1_use_mem_reg <= issue.use_mem;
            s1_data_reg    <= issue.data;
        end
        if (move)
        begin
            out_status_reg <= s1_status_reg;
            out_data_reg   <= s1_use_mem_reg ? rd_data : s1_data_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.data_out = out_data_reg;

endmodule

// ===== src/double_ended_queue_top.sv =====
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries (deq_pkg).
// Each item on req carries an opcode and a push value and yields exactly one item
// on rsp with a status (ok, empty, full) and a data word: the popped or peeked
// value, the element count for size, zero otherwise. Items are taken one per
// clock unless both result stages are full and rsp is not ready; a result passes
// through stage 1, where the ring RAM read lands, and the output register. Front
// and count pointers update in the accept cycle, so back-to-back items see each
// other's effects. Clear empties the queue at once; the ring contents stay.
module double_ended_queue_top import deq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);

    logic              issue_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    deq_issue_t        issue;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .issue_ok (issue_ok),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .issue    (issue)
    );

    deq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    deq_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .rd_data  (rd_data),
        .issue_ok (issue_ok),
        .rsp      (rsp)
    );

endmodule

// ===== tb/deq_checker.sv =====
module deq_checker import deq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    deq_in_if    req,
    deq_out_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data;
    } deq_result_t;

    deq_result_t       expected_results[$];
    logic [DATA_W-1:0] ring_copy [DEPTH];
    logic [ADDR_W-1:0] head;
    logic [CNT_W-1:0]  fill;

    function automatic deq_result_t predict_deque_op(opcode_t op, logic [DATA_W-1:0] value);
        deq_result_t res;
        int          slot;
        res.status = ST_OK;
        res.data   = '0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (int'(fill) == DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    if (op == OP_PUSH_BACK)
                        slot = (int'(head) + int'(fill)) % DEPTH;
                    else
                    begin
                        slot = (head == '0) ? DEPTH - 1 : int'(head) - 1;
                        head = ADDR_W'(slot);
                    end
                    ring_copy[slot] = value;
                    fill = fill + 1'b1;
                end
            end
            OP_POP_BACK, OP_BACK:
            begin
                if (fill == '0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.data = ring_copy[(int'(head) + int'(fill) - 1) % DEPTH];
                    if (op == OP_POP_BACK)
                        fill = fill - 1'b1;
                end
            end
            OP_POP_FRONT, OP_FRONT:
            begin
                if (fill == '0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.data = ring_copy[head];
                    if (op == OP_POP_FRONT)
                    begin
                        head = ADDR_W'((int'(head) + 1) % DEPTH);
                        fill = fill - 1'b1;
                    end
                end
            end
            OP_SIZE:
                res.data = DATA_W'(fill);
            OP_CLEAR:
            begin
                fill = '0;
                head = '0;
            end
            default:
                res.data = '0;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        if (!rst_n)
        begin
            head = '0;
            fill = '0;
            expected_results.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results = {expected_results,
                    predict_deque_op(opcode_t'(req.opcode), req.push_value)};
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item: status %0d data %h",
                             $time, rsp.status, rsp.data_out);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (rsp.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.data_out !== want.data)
                    begin
                        mismatches++;
                        $display("%0t: data_out mismatch: expected %h, actual %h",
                                 $time, want.data, rsp.data_out);
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench import deq_pkg::*; ();

    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int FILL_PUSHES = 250;
    localparam int DRAIN_POPS  = 260;

    logic clk;
    logic rst_n = 1'b0;
    logic calm = 1'b0;
    logic hold_rsp = 1'b0;
    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;

    deq_in_if  req_bus ();
    deq_out_if rsp_bus ();

    double_ended_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    deq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog: no progress for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] value);
        int gap;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.opcode     <= op;
        req_bus.push_value <= value;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int      r;
        opcode_t op;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (r == 99)
            op = OP_CLEAR;
        else
            op = opcode_t'($urandom_range(OP_BACK, OP_SIZE));
        send_item(op, pick_value());
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // receive side
    initial
    begin
        int stall;
        bit held;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp && !held)
            begin
                held = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, 4);
                if (stall > 0)
                begin
                    rsp_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_bus.valid);
        end
    end

    initial
    begin
        int pushes;
        int pops;
        req_bus.valid      <= 1'b0;
        req_bus.opcode     <= OP_SIZE;
        req_bus.push_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, front wrap, extremes of the value
        send_item(OP_POP_BACK, 32'h1234_5678);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_BACK, '0);
        send_item(OP_FRONT, '1);
        send_item(OP_SIZE, '0);
        send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_item(OP_PUSH_BACK, 32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'hffff_ffff);
        send_item(OP_PUSH_BACK, 32'h0000_0000);
        send_item(OP_FRONT, '0);
        send_item(OP_BACK, '0);
        send_item(OP_SIZE, '0);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_POP_BACK, '0);
        send_item(OP_PUSH_BACK, 32'h5555_aaaa);
        send_item(OP_BACK, '0);
        send_item(OP_FRONT, '0);
        send_item(OP_CLEAR, 32'hdead_beef);
        send_item(OP_SIZE, '0);
        send_item(OP_FRONT, '0);
        send_item(OP_PUSH_BACK, 32'ha5a5_a5a5);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_POP_BACK, '0);
        wait_drained();

        for (int i = 0; i < 200; i++)
        begin
            if (i == 100)
                hold_rsp = 1'b1;
            send_random(45, 35);
        end

        // long run of pushes, then drain past empty
        send_item(OP_CLEAR, pick_value());
        pushes = 0;
        while (pushes < FILL_PUSHES)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(opcode_t'($urandom_range(OP_BACK, OP_SIZE)), pick_value());
            else
            begin
                send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
                pushes++;
            end
        end
        pops = 0;
        while (pops < DRAIN_POPS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(opcode_t'($urandom_range(OP_BACK, OP_SIZE)), pick_value());
            else
            begin
                send_item($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
                pops++;
            end
        end
        wait_drained();

        // refill partway, clear from a loaded queue
        repeat (40)
            send_random(70, 20);
        send_item(OP_CLEAR, pick_value());

        repeat (20)
            send_random(50, 30);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
